// ===== design/snp_pkg.sv =====
`default_nettype none
package snp_pkg;
    localparam int MAX_CACHES  = 4;
    localparam int CACHE_BYTES = 65536;
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 64;

    localparam int NSETS_RAW = CACHE_BYTES / (BLOCK_BYTES * WAYS);
    localparam int NSETS     = (NSETS_RAW > 0) ? NSETS_RAW : 1;
    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int SETB      = $clog2(NSETS);
    localparam int SET_W     = (SETB > 0) ? SETB : 1;
    localparam int TAG_W     = 32 - OFF_W - SETB;
    localparam int RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W     = RANK_W;
    localparam int CNT_W     = $clog2(MAX_CACHES + 1);
    localparam int LINE_W    = TAG_W + RANK_W + 3;
    localparam int ROW_W     = WAYS * LINE_W;

    localparam logic [2:0] ST_I  = 3'd0;
    localparam logic [2:0] ST_S  = 3'd1;
    localparam logic [2:0] ST_E  = 3'd2;
    localparam logic [2:0] ST_M  = 3'd3;
    localparam logic [2:0] ST_SC = 3'd4;
    localparam logic [2:0] ST_SM = 3'd5;

    localparam logic [2:0] BUS_NONE = 3'd0;
    localparam logic [2:0] BUS_RD   = 3'd1;
    localparam logic [2:0] BUS_RDX  = 3'd2;
    localparam logic [2:0] BUS_UPGR = 3'd3;
    localparam logic [2:0] BUS_UPD  = 3'd4;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_FLUSH = 2'd1;
    localparam logic [1:0] KIND_OPT   = 2'd2;

    localparam logic [1:0] PR_MSI    = 2'd0;
    localparam logic [1:0] PR_MESI   = 2'd1;
    localparam logic [1:0] PR_DRAGON = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
        logic [2:0]        st;
    } t_line;

    typedef t_line [WAYS-1:0] t_row;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } t_find;

    typedef struct packed {
        logic [2:0] mt;
        logic [1:0] inv;
        logic [2:0] ns;
        logic       copies;
        logic [1:0] kind;
        logic [1:0] supid;
        logic       supv;
        logic [2:0] bus;
        logic       wb;
        logic       hit;
    } t_res;

    typedef struct packed {
        logic clr;
        logic cap;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic slot_free;
    } t_sts;

    function automatic t_find f_find(input t_row row, input logic [TAG_W-1:0] tag);
        t_find r;
        r = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row[w].st != ST_I && row[w].tag == tag) begin
                r.hit = 1'b1;
                r.way = WAY_W'(w);
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== design/snp_ram.sv =====
`default_nettype none
module snp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/snp_ctrl.sv =====
`default_nettype none
module snp_ctrl
    import snp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE: if (i_valid) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: if (i_sts.slot_free) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_cmd.clr = (r_state == S_CLR);
    assign o_cmd.cap = (r_state == S_IDLE) && i_valid;
    // hold the finished request until the result register frees up
    assign o_cmd.upd = (r_state == S_EXEC) && i_sts.slot_free;
endmodule
`default_nettype wire

// ===== design/snp_dp.sv =====
`default_nettype none
module snp_dp
    import snp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [1:0]  i_protocol,
    input  wire logic [2:0]  i_active,
    input  wire logic [1:0]  i_proc_id,
    input  wire logic        i_cmd_wr,
    input  wire logic [31:0] i_addr,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_res             o_res
);
    logic [1:0]       r_pid;
    logic             r_wr;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic [SET_W-1:0] r_clr_addr;
    logic             r_valid;
    t_res             r_res;

    logic [ROW_W-1:0] rdata [MAX_CACHES];
    logic [ROW_W-1:0] wdata [MAX_CACHES];
    t_row             new_row [MAX_CACHES];
    logic             row_we;
    t_res             res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pid <= i_proc_id;
            r_wr  <= i_cmd_wr;
            r_set <= (SETB > 0) ? SET_W'(i_addr >> OFF_W) : '0;
            r_tag <= TAG_W'(i_addr >> (OFF_W + SETB));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == SET_W'(NSETS - 1));
    assign o_sts.slot_free = !r_valid || i_ready;

    always_comb begin
        t_row        rows [MAX_CACHES];
        t_row        rq;
        t_find       fr;
        t_find       fo;
        logic [CNT_W:0] n_eff;
        logic        act;
        logic [1:0]  proto;
        logic        wr;
        logic [WAY_W-1:0] way;
        logic [WAY_W-1:0] vic;
        logic        found_inv;
        logic [2:0]  cs;
        logic [2:0]  vs;
        logic [2:0]  os;
        logic [2:0]  bus;
        logic        was_valid;
        logic [RANK_W:0] r;
        logic [2:0]  ns;
        logic        copies;
        logic        supv;
        logic [1:0]  supid;
        logic [1:0]  kind;
        logic [1:0]  inv;
        logic [2:0]  mt;
        logic        sup_k;
        logic        kset_k;
        logic [1:0]  kval_k;
        logic [2:0]  nos;

        for (int c = 0; c < MAX_CACHES; c++) begin
            rows[c] = t_row'(rdata[c]);
        end
        if (i_active == 3'd0)                       n_eff = (CNT_W+1)'(1);
        else if ({1'b0, i_active} > 4'(MAX_CACHES)) n_eff = (CNT_W+1)'(MAX_CACHES);
        else                                        n_eff = (CNT_W+1)'(i_active);
        act   = ((CNT_W+1)'(r_pid) < n_eff);
        proto = (i_protocol == 2'd3) ? PR_MSI : i_protocol;
        wr    = r_wr;
        rq    = rows[r_pid];
        fr    = f_find(rq, r_tag);

        // victim: lowest invalid way, else highest rank with lowest index
        found_inv = 1'b0;
        vic       = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rq[w].st == ST_I) begin
                found_inv = 1'b1;
                vic       = WAY_W'(w);
            end
        end
        if (!found_inv) begin
            for (int w = 1; w < WAYS; w++) begin
                if (rq[w].rank > rq[vic].rank) vic = WAY_W'(w);
            end
        end

        mt  = '0;
        bus = BUS_NONE;
        cs  = ST_I;
        vs  = ST_I;
        res = '0;
        if (!fr.hit) begin
            way = vic;
            vs  = rq[vic].st;
            res.wb = (vs == ST_M) || (proto == PR_DRAGON && vs == ST_SM);
            if (res.wb) mt = mt + 3'd1;
            bus = !wr ? BUS_RD : ((proto == PR_DRAGON) ? BUS_UPD : BUS_RDX);
        end else begin
            way = fr.way;
            cs  = rq[way].st;
            if (wr) begin
                if (proto == PR_MSI && cs == ST_S)       bus = BUS_RDX;
                else if (proto == PR_MESI && cs == ST_S) bus = BUS_UPGR;
                else if (proto == PR_DRAGON && (cs == ST_SC || cs == ST_SM)) bus = BUS_UPD;
            end
        end
        was_valid = (rq[way].st != ST_I);

        copies = 1'b0;
        supv   = 1'b0;
        supid  = '0;
        kind   = KIND_NONE;
        inv    = '0;
        for (int c = 0; c < MAX_CACHES; c++) begin
            new_row[c] = rows[c];
        end
        if (bus != BUS_NONE) begin
            if (proto == PR_MSI) mt = mt + 3'd1;
            for (int c = 0; c < MAX_CACHES; c++) begin
                fo     = f_find(rows[c], r_tag);
                os     = rows[c][fo.way].st;
                sup_k  = 1'b0;
                kset_k = 1'b0;
                kval_k = KIND_FLUSH;
                nos    = os;
                if (fo.hit && c != int'(r_pid) && (CNT_W+1)'(c) < n_eff) begin
                    copies = 1'b1;
                    unique case (proto)
                        PR_MSI: begin
                            if (bus == BUS_RD) begin
                                if (os == ST_M) begin
                                    nos = ST_S; mt = mt + 3'd1; sup_k = 1'b1; kset_k = 1'b1;
                                end
                            end else begin
                                inv = inv + 2'd1;
                                if (os == ST_M) begin
                                    mt = mt + 3'd1; sup_k = 1'b1; kset_k = 1'b1;
                                end
                                nos = ST_I;
                            end
                        end
                        PR_MESI: begin
                            if (bus == BUS_RD || bus == BUS_RDX) begin
                                sup_k  = 1'b1;
                                kset_k = 1'b1;
                                kval_k = (os == ST_M) ? KIND_FLUSH : KIND_OPT;
                                if (os == ST_M) mt = mt + 3'd1;
                                if (bus == BUS_RD) begin
                                    nos = ST_S;
                                end else begin
                                    nos = ST_I;
                                    inv = inv + 2'd1;
                                end
                            end else if (os == ST_S) begin
                                nos = ST_I;
                                inv = inv + 2'd1;
                            end
                        end
                        default: begin
                            if (os == ST_M) begin
                                mt = mt + 3'd1; sup_k = 1'b1; kset_k = 1'b1;
                                nos = (bus == BUS_RD) ? ST_SM : ST_SC;
                            end else if (os == ST_E) begin
                                nos = ST_SC; sup_k = 1'b1;
                            end else if (os == ST_SM) begin
                                if (bus == BUS_RD || !fr.hit) mt = mt + 3'd1;
                                sup_k = 1'b1; kset_k = 1'b1;
                                if (bus != BUS_RD) nos = ST_SC;
                            end else if (os == ST_SC) begin
                                sup_k = 1'b1;
                            end
                        end
                    endcase
                    new_row[c][fo.way].st = nos;
                    if (sup_k) begin
                        supv  = 1'b1;
                        supid = 2'(c);
                    end
                    if (kset_k) kind = kval_k;
                end
            end
            if (proto == PR_MESI && (bus == BUS_RD || bus == BUS_RDX) && !supv) mt = mt + 3'd1;
            if (proto == PR_DRAGON && bus == BUS_RD && kind != KIND_FLUSH) mt = mt + 3'd1;
            if (proto == PR_DRAGON && bus == BUS_UPD && !fr.hit && kind != KIND_FLUSH)
                mt = mt + 3'd1;
        end

        if (proto == PR_DRAGON) begin
            if (fr.hit) begin
                if (!wr)            ns = cs;
                else if (cs == ST_E) ns = ST_M;
                else                ns = copies ? ST_SM : ST_M;
            end else if (wr) begin
                ns = copies ? ST_SM : ST_M;
            end else begin
                ns = copies ? ST_SC : ST_E;
            end
        end else begin
            if (wr)                  ns = ST_M;
            else if (fr.hit)         ns = cs;
            else if (proto == PR_MSI) ns = ST_S;
            else                     ns = copies ? ST_S : ST_E;
        end

        // age the lines that were more recent than the touched one
        r = was_valid ? {1'b0, rq[way].rank} : (RANK_W+1)'(WAYS - 1);
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) != way && {1'b0, rq[w].rank} < r)
                new_row[r_pid][w].rank = rq[w].rank + 1'b1;
        end
        new_row[r_pid][way].tag  = r_tag;
        new_row[r_pid][way].st   = ns;
        new_row[r_pid][way].rank = '0;

        res.hit    = fr.hit;
        res.bus    = bus;
        res.supv   = supv;
        res.supid  = supid;
        res.kind   = kind;
        res.copies = copies;
        res.ns     = ns;
        res.inv    = inv;
        res.mt     = mt;
        if (!act) res = '0;
        row_we = act;
    end

    for (genvar g = 0; g < MAX_CACHES; g++) begin : g_cache
        assign wdata[g] = i_cmd.clr ? '0 : ROW_W'(new_row[g]);
        snp_ram #(
            .WIDTH(ROW_W),
            .DEPTH(NSETS)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (i_cmd.clr || (i_cmd.upd && row_we)),
            .i_waddr(i_cmd.clr ? r_clr_addr : r_set),
            .i_wdata(wdata[g]),
            .i_raddr(r_set),
            .o_rdata(rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.upd) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_res <= res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule
`default_nettype wire

// ===== design/snoop_coherence_controller_core.sv =====
// Channel  | Direction | Payload
// s_*      | in        | tdata: proc_id, cmd, addr
// m_*      | out       | tdata: hit .. memory_transactions (19 bits)
// APB      | in/out    | protocol at 0x0, active_caches at 0x4
//
// A request is accepted, its set is read from the per-cache tag RAMs, and
// then lookup, snoop and RAM write-back happen together in the EXEC state.
// The single RAM read port per cache sets that order.
// After reset the tag RAMs are cleared, one set per cycle (NSETS = 256 sets),
// with s_tready low; config writes are taken throughout.
// A stalled result holds the next request in the EXEC state.
`default_nettype none
module snoop_coherence_controller_core
    import snp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // proc_id[1:0], cmd[2], addr[34:3], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // hit, victim_writeback, bus_request[4:2],
                                        // supplier_valid, supplier_id[7:6],
                                        // supply_kind[9:8], copies_seen,
                                        // new_line_state[13:11], invalidations[15:14],
                                        // memory_transactions[18:16], zero pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [1:0] r_protocol;
    logic [2:0] r_active;
    t_cmd       cmd;
    t_sts       sts;
    t_res       res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol <= PR_MSI;
            r_active   <= 3'd4;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_active   <= pwdata[2:0];
            else          r_protocol <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {29'd0, r_active} : {30'd0, r_protocol};

    snp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_tvalid),
        .o_ready(s_tready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    snp_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_protocol(r_protocol),
        .i_active  (r_active),
        .i_proc_id (s_tdata[1:0]),
        .i_cmd_wr  (s_tdata[2]),
        .i_addr    (s_tdata[34:3]),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_res     (res)
    );

    assign m_tdata = {5'd0, res};
endmodule
`default_nettype wire

// ===== design/snp_chk.sv =====
`default_nettype none
module snp_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while busy");

    a_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[4:2] <= 3'd4 && m_tdata[13:11] <= 3'd5)
        else $error("bad bus command or line state");

    a_sup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[5] |-> m_tdata[7:6] == 2'd0 && m_tdata[9:8] == 2'd0)
        else $error("supplier fields without a supplier");

    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");
endmodule

bind snoop_coherence_controller_core snp_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .pready  (pready)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

class coherence_scoreboard;
    logic [18:0] pending_results[$];
    int          errors;

    function void note_request(logic [18:0] res);
        pending_results.push_back(res);
    endfunction

    function void check_result(logic [23:0] got);
        logic [18:0] exp;
        if (pending_results.size() == 0) begin
            $error("result with no request pending: %h", got);
            errors++;
            return;
        end
        exp = pending_results.pop_front();
        if (got[0] !== exp[0]) begin
            $error("hit exp %0d got %0d", exp[0], got[0]); errors++;
        end
        if (got[1] !== exp[1]) begin
            $error("victim_writeback exp %0d got %0d", exp[1], got[1]); errors++;
        end
        if (got[4:2] !== exp[4:2]) begin
            $error("bus_request exp %0d got %0d", exp[4:2], got[4:2]); errors++;
        end
        if (got[5] !== exp[5]) begin
            $error("supplier_valid exp %0d got %0d", exp[5], got[5]); errors++;
        end
        if (got[7:6] !== exp[7:6]) begin
            $error("supplier_id exp %0d got %0d", exp[7:6], got[7:6]); errors++;
        end
        if (got[9:8] !== exp[9:8]) begin
            $error("supply_kind exp %0d got %0d", exp[9:8], got[9:8]); errors++;
        end
        if (got[10] !== exp[10]) begin
            $error("copies_seen exp %0d got %0d", exp[10], got[10]); errors++;
        end
        if (got[13:11] !== exp[13:11]) begin
            $error("new_line_state exp %0d got %0d", exp[13:11], got[13:11]); errors++;
        end
        if (got[15:14] !== exp[15:14]) begin
            $error("invalidations exp %0d got %0d", exp[15:14], got[15:14]); errors++;
        end
        if (got[18:16] !== exp[18:16]) begin
            $error("memory_transactions exp %0d got %0d", exp[18:16], got[18:16]);
            errors++;
        end
        if (got[23:19] !== 5'd0) begin
            $error("pad exp 0 got %0h", got[23:19]); errors++;
        end
    endfunction
endclass

module tb_top;
    import snp_pkg::*;

    localparam int LINES = MAX_CACHES * NSETS * WAYS;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    snoop_coherence_controller_core uut (.*);

    always #10 i_clk = ~i_clk;

    coherence_scoreboard sb = new();

    // mirror of the caches
    logic [TAG_W-1:0] mir_tag[LINES];
    logic [2:0]       mir_st[LINES];
    logic [1:0]       mir_rank[LINES];
    logic [1:0]       mir_protocol;
    logic [2:0]       mir_active;

    int send_idle_pct, recv_idle_pct;
    bit hold_off;

    function automatic int line_base(int c, int set);
        return (c * NSETS + set) * WAYS;
    endfunction

    function automatic int find_line(int b, logic [TAG_W-1:0] tag);
        for (int w = 0; w < WAYS; w++)
            if (mir_st[b + w] != ST_I && mir_tag[b + w] == tag) return w;
        return -1;
    endfunction

    function automatic logic [18:0] predict_coherence(logic [1:0] p, logic wr,
                                                       logic [31:0] addr);
        int n, proto, set, b, f, way, ob, ow, k, r, best;
        logic [2:0] bus, cs, ns, os, vs;
        logic [1:0] kind, supid;
        int inv, mt;
        logic hit, wb, supv, copies, was_valid;
        logic [TAG_W-1:0] tag;
        bus = BUS_NONE; kind = KIND_NONE; supid = 0; inv = 0; mt = 0;
        cs = ST_I; wb = 0; supv = 0; copies = 0;
        n = mir_active;
        if (n == 0) n = 1;
        if (n > MAX_CACHES) n = MAX_CACHES;
        if (p >= n) return '0;
        proto = (mir_protocol == 2'd3) ? PR_MSI : mir_protocol;
        set = (addr >> OFF_W) % NSETS;
        tag = TAG_W'(addr >> (OFF_W + SETB));
        b = line_base(p, set);
        f = find_line(b, tag);
        hit = f >= 0;
        if (!hit) begin
            way = -1;
            for (int w = 0; w < WAYS; w++)
                if (way < 0 && mir_st[b + w] == ST_I) way = w;
            if (way < 0) begin
                best = 0;
                for (int w = 1; w < WAYS; w++)
                    if (mir_rank[b + w] > mir_rank[b + best]) best = w;
                way = best;
            end
            vs = mir_st[b + way];
            if (vs == ST_M || (proto == PR_DRAGON && vs == ST_SM)) begin
                wb = 1; mt++;
            end
            bus = !wr ? BUS_RD : (proto == PR_DRAGON ? BUS_UPD : BUS_RDX);
        end else begin
            way = f;
            cs = mir_st[b + way];
            if (wr) begin
                if (proto == PR_MSI && cs == ST_S) bus = BUS_RDX;
                else if (proto == PR_MESI && cs == ST_S) bus = BUS_UPGR;
                else if (proto == PR_DRAGON && (cs == ST_SC || cs == ST_SM)) bus = BUS_UPD;
            end
        end
        was_valid = mir_st[b + way] != ST_I;

        if (bus != BUS_NONE) begin
            if (proto == PR_MSI) mt++;
            for (int i = 0; i < n; i++) begin
                if (i == p) continue;
                ob = line_base(i, set);
                ow = find_line(ob, tag);
                if (ow < 0) continue;
                k = ob + ow;
                os = mir_st[k];
                copies = 1;
                if (proto == PR_MSI) begin
                    if (bus == BUS_RD) begin
                        if (os == ST_M) begin
                            mir_st[k] = ST_S; mt++; supv = 1; supid = i; kind = KIND_FLUSH;
                        end
                    end else begin
                        inv++;
                        if (os == ST_M) begin
                            mt++; supv = 1; supid = i; kind = KIND_FLUSH;
                        end
                        mir_st[k] = ST_I;
                    end
                end else if (proto == PR_MESI) begin
                    if (bus == BUS_RD || bus == BUS_RDX) begin
                        if (bus == BUS_RDX) inv++;
                        if (os == ST_M) begin
                            mt++; kind = KIND_FLUSH;
                        end else kind = KIND_OPT;
                        supv = 1; supid = i;
                        mir_st[k] = (bus == BUS_RD) ? ST_S : ST_I;
                    end else if (os == ST_S) begin
                        mir_st[k] = ST_I; inv++;
                    end
                end else begin
                    if (bus == BUS_RD) begin
                        if (os == ST_M) begin
                            mt++; mir_st[k] = ST_SM; supv = 1; supid = i; kind = KIND_FLUSH;
                        end else if (os == ST_E) begin
                            mir_st[k] = ST_SC; supv = 1; supid = i;
                        end else if (os == ST_SM) begin
                            mt++; supv = 1; supid = i; kind = KIND_FLUSH;
                        end else if (os == ST_SC) begin
                            supv = 1; supid = i;
                        end
                    end else begin
                        if (os == ST_M) begin
                            mt++; mir_st[k] = ST_SC; supv = 1; supid = i; kind = KIND_FLUSH;
                        end else if (os == ST_E) begin
                            mir_st[k] = ST_SC; supv = 1; supid = i;
                        end else if (os == ST_SM) begin
                            if (!hit) mt++;
                            supv = 1; supid = i; kind = KIND_FLUSH;
                            mir_st[k] = ST_SC;
                        end else if (os == ST_SC) begin
                            supv = 1; supid = i;
                        end
                    end
                end
            end
            if (proto == PR_MESI && (bus == BUS_RD || bus == BUS_RDX) && !supv) mt++;
            if (proto == PR_DRAGON && bus == BUS_RD && kind != KIND_FLUSH) mt++;
            if (proto == PR_DRAGON && bus == BUS_UPD && !hit && kind != KIND_FLUSH) mt++;
        end

        if (proto == PR_DRAGON) begin
            if (hit) begin
                if (!wr) ns = cs;
                else if (cs == ST_E) ns = ST_M;
                else ns = copies ? ST_SM : ST_M;
            end else if (wr) ns = copies ? ST_SM : ST_M;
            else ns = copies ? ST_SC : ST_E;
        end else begin
            if (wr) ns = ST_M;
            else if (hit) ns = cs;
            else if (proto == PR_MSI) ns = ST_S;
            else ns = copies ? ST_S : ST_E;
        end

        mir_tag[b + way] = tag;
        mir_st[b + way] = ns;
        r = was_valid ? mir_rank[b + way] : WAYS - 1;
        for (int w = 0; w < WAYS; w++)
            if (w != way && mir_rank[b + w] < r) mir_rank[b + w]++;
        mir_rank[b + way] = 0;

        return {3'(mt), 2'(inv), ns, copies, kind, supv ? supid : 2'd0, supv, bus, wb, hit};
    endfunction

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_config(logic [1:0] proto, logic [2:0] active);
        wait (sb.pending_results.size() == 0);
        repeat (8) @(posedge i_clk);
        apb_write(3'd0, proto);
        apb_write(3'd4, active);
        mir_protocol = proto;
        mir_active = active;
    endtask

    task automatic send_request(logic [1:0] p, logic wr, logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, addr, wr, p};
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(predict_coherence(p, wr, addr));
        // the block is busy after a transfer, so drop valid before the next request
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // addresses from a small pool of tags in a few sets, to force sharing and eviction
    function automatic logic [31:0] pool_addr();
        logic [31:0] a;
        a = $urandom();
        a[OFF_W +: SETB] = $urandom_range(3);
        a[31 -: TAG_W] = $urandom_range(6);
        return a;
    endfunction

    task automatic random_phase(int count, int max_p);
        for (int j = 0; j < count; j++) begin
            if ($urandom_range(9) == 0)
                send_request($urandom_range(3), $urandom_range(1), $urandom());
            else
                send_request($urandom_range(max_p), $urandom_range(1), pool_addr());
        end
    endtask

    always @(posedge i_clk) begin
        if (m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int spin;
        for (int k = 0; k < LINES; k++) begin
            mir_tag[k] = '0; mir_st[k] = ST_I; mir_rank[k] = '0;
        end
        mir_protocol = PR_MSI;
        mir_active = 3'd4;
        send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: sharing, upgrade, dirty flush, eviction under each protocol
        for (int pr = 0; pr < 3; pr++) begin
            set_config(pr, 3'd4);
            send_request(2'd0, 1'b0, 32'h0000_0040);
            send_request(2'd1, 1'b0, 32'h0000_0040);
            send_request(2'd1, 1'b1, 32'h0000_0040);
            send_request(2'd2, 1'b0, 32'h0000_0040);
            send_request(2'd3, 1'b1, 32'h0000_0040);
            send_request(2'd0, 1'b1, 32'h0000_0040);
            for (int t = 1; t <= 5; t++) send_request(2'd0, 1'b1, {t[15:0], 16'h0040});
        end
        send_request(2'd3, 1'b1, 32'hFFFF_FFFF);
        send_request(2'd0, 1'b0, 32'h0000_0000);
        set_config(2'd3, 3'd0);
        send_request(2'd1, 1'b0, 32'h0000_0000);
        send_request(2'd0, 1'b1, 32'h0000_0000);
        set_config(2'd1, 3'd7);
        send_request(2'd3, 1'b0, 32'h0000_0000);

        send_idle_pct = 29; recv_idle_pct = 72;
        set_config(PR_MESI, 3'd4);
        random_phase(250, 3);
        // long receiver stall: fill the pipe until the input backs up
        hold_off = 1;
        fork
            begin
                spin = 0;
                while (spin < 200) begin @(posedge i_clk); spin++; end
                hold_off = 0;
            end
            random_phase(20, 3);
        join
        wait (sb.pending_results.size() == 0);
        send_idle_pct = 72; recv_idle_pct = 29;
        set_config(PR_DRAGON, 3'd3);
        random_phase(250, 3);
        set_config(PR_MSI, 3'd2);
        random_phase(150, 3);
        send_idle_pct = 0; recv_idle_pct = 0;
        set_config(PR_DRAGON, 3'd4);
        random_phase(250, 3);
        set_config(PR_MESI, 3'd1);
        random_phase(80, 3);
        set_config($urandom_range(3), $urandom_range(7));
        random_phase(250, 3);

        wait (sb.pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
design/snp_pkg.sv
design/snp_ram.sv
design/snp_ctrl.sv
design/snp_dp.sv
design/snoop_coherence_controller_core.sv
design/snp_chk.sv
tb/tb_top.sv
